>>> hw/rtl/pcc_pkg.sv
// Shared constants for the polygon/circle collision block.
`default_nettype none
package pcc_pkg;
   localparam int FRAC_BITS = 16;
   localparam int CW        = 32;
   localparam int RW        = 31;
   localparam int NW        = 18;
   localparam int NMAX      = 131071;
endpackage
`default_nettype wire

>>> hw/rtl/pcc_channels.sv
// Request and response channel interfaces of the polygon/circle collision block.
`default_nettype none
interface pcc_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [pcc_pkg::CW-1:0] vertex_x;
   logic signed [pcc_pkg::CW-1:0] vertex_y;
   logic                          last_vertex;
   logic signed [pcc_pkg::CW-1:0] poly_pos_x;
   logic signed [pcc_pkg::CW-1:0] poly_pos_y;
   logic signed [pcc_pkg::CW-1:0] circle_x;
   logic signed [pcc_pkg::CW-1:0] circle_y;
   logic        [pcc_pkg::RW-1:0] circle_radius;

   modport source (output valid, vertex_x, vertex_y, last_vertex, poly_pos_x, poly_pos_y,
                   circle_x, circle_y, circle_radius, input ready);
   modport sink   (input valid, vertex_x, vertex_y, last_vertex, poly_pos_x, poly_pos_y,
                   circle_x, circle_y, circle_radius, output ready);
endinterface

interface pcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [pcc_pkg::CW-1:0] depth;
   logic signed [pcc_pkg::NW-1:0] normal_x;
   logic signed [pcc_pkg::NW-1:0] normal_y;
   logic signed [pcc_pkg::CW-1:0] start_x;
   logic signed [pcc_pkg::CW-1:0] start_y;
   logic signed [pcc_pkg::CW-1:0] end_x;
   logic signed [pcc_pkg::CW-1:0] end_y;

   modport source (output valid, hit, depth, normal_x, normal_y, start_x, start_y,
                   end_x, end_y, input ready);
   modport sink   (input valid, hit, depth, normal_x, normal_y, start_x, start_y,
                   end_x, end_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/polygon_circle_collision.sv
// Polygon/circle collision: streamed vertices, one shared multiplier, sqrt and divide sequencer.
//
//  channel  | dir | handshake      | carries
//  req_ch   | in  | valid / ready  | one polygon vertex, position, circle
//  rsp_ch   | out | valid / ready  | hit, depth, normal, start and end point
//
// The first vertex of a polygon is only stored, unless it is also the last. Every other vertex
// closes one edge through the vector unit (up to 30 normalising shifts, 32 root steps,
// 2*(FRAC_BITS+1) divide steps; none for a zero-length edge). The last vertex adds the
// closing edge and up to four more vector passes. req_ch.ready is high only while the
// sequencer is idle; a waiting response does not stall requests until the next polygon
// finishes. Reset is synchronous and clears the polygon state.
`default_nettype none
module polygon_circle_collision (
   input  wire        clock,
   input  wire        reset,
   pcc_req_if.sink    req_ch,
   pcc_rsp_if.source  rsp_ch
);
   localparam int F    = pcc_pkg::FRAC_BITS;
   localparam int CW   = pcc_pkg::CW;
   localparam int RW   = pcc_pkg::RW;
   localparam int NW   = pcc_pkg::NW;
   localparam int OPW  = CW + 2;
   localparam int MW   = OPW - 1;
   localparam int PW   = 2 * OPW;
   localparam int ACCW = PW + 1;
   localparam int SQW  = 2 * CW;
   localparam int LENW = CW + 3;
   localparam int QW   = F + 1;
   localparam int DCW  = $clog2(F + 1);
   localparam int REMW = CW + 2;

   localparam logic signed [ACCW-1:0] S_MAX = {{(ACCW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [ACCW-1:0] S_MIN = {{(ACCW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   typedef enum logic [4:0] {
      S_IDLE, S_EDGE, S_DOT0, S_DOT1, S_DOT2, S_ESEP, S_CLS, S_CPROJ, S_CCMP, S_CDIST,
      S_CNRM, S_O0, S_O1, S_O2, S_O3, S_O4, S_DONE, S_VABS, S_VNORM, S_VSQ0, S_VSQ1,
      S_VSQ2, S_VSQRT, S_VDIVX, S_VDIVY
   } state_type;

   function automatic logic signed [CW-1:0] sat(input logic signed [ACCW-1:0] v,
                                                input logic sym);
      logic signed [ACCW-1:0] lo;
      lo = sym ? S_MIN + 1 : S_MIN;
      if (v > S_MAX) return S_MAX[CW-1:0];
      else if (v < lo) return lo[CW-1:0];
      else return v[CW-1:0];
   endfunction

   function automatic logic signed [ACCW-1:0] sxa(input logic signed [CW-1:0] v);
      return {{(ACCW-CW){v[CW-1]}}, v};
   endfunction

   function automatic logic signed [OPW-1:0] sxo(input logic signed [CW-1:0] v);
      return {{(OPW-CW){v[CW-1]}}, v};
   endfunction

   function automatic logic signed [OPW-1:0] sxn(input logic signed [NW-1:0] v);
      return {{(OPW-NW){v[NW-1]}}, v};
   endfunction

   state_type state_ff, ret_ff;
   logic have_first_ff, outside_ff, closing_ff, last_ff, in_cls_ff, unit_ff, hit_ff;
   logic rsp_valid_ff;
   logic signed [CW-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff, w_x_ff, w_y_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic        [RW-1:0] r_ff;
   logic signed [CW-1:0] e_x1_ff, e_y1_ff, e_x2_ff, e_y2_ff;
   logic signed [CW-1:0] best_sep_ff, b_x1_ff, b_y1_ff, b_x2_ff, b_y2_ff;
   logic signed [NW-1:0] best_nx_ff, best_ny_ff;
   logic signed [OPW-1:0] op_x_ff, op_y_ff, d_x_ff, d_y_ff;
   logic [MW-1:0]   ax_ff, ay_ff;
   logic [1:0]      k_ff;
   logic [SQW-1:0]  sumsq_ff, root_ff;
   logic [SQW-2:0]  bit_ff;
   logic [REMW-1:0] rem_ff;
   logic [QW-1:0]   quo_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic signed [NW-1:0] nx_ff, ny_ff, fn_x_ff, fn_y_ff;
   logic [LENW-1:0] len_ff;
   logic signed [ACCW-1:0] acc_ff, proj_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [CW-1:0] depth_ff, sx_ff, sy_ff, ex_ff, ey_ff;
   logic                 o_hit_ff;
   logic signed [CW-1:0] o_depth_ff, o_sx_ff, o_sy_ff, o_ex_ff, o_ey_ff;
   logic signed [NW-1:0] o_nx_ff, o_ny_ff;

   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [CW:0]    wx_sum, wy_sum;
   logic signed [CW-1:0]  wx, wy;
   logic [MW-1:0]         mag_max;
   logic [SQW-1:0]        sq_t;
   logic                  sq_ge;
   logic [SQW-1:0]        root_nx, sumsq_nx;
   logic [REMW-1:0]       div_d, rem_sub, rem_nx;
   logic                  div_take;
   logic [QW-1:0]         quo_nx;
   logic [NW-1:0]         q_cap;
   logic signed [NW-1:0]  q_signed;
   logic signed [ACCW-1:0] prod_sh, acc_sh;
   logic [LENW-1:0]       len_nx;

   assign wx_sum = {req_ch.vertex_x[CW-1], req_ch.vertex_x}
                 + {req_ch.poly_pos_x[CW-1], req_ch.poly_pos_x};
   assign wy_sum = {req_ch.vertex_y[CW-1], req_ch.vertex_y}
                 + {req_ch.poly_pos_y[CW-1], req_ch.poly_pos_y};
   assign wx = sat({{(ACCW-CW-1){wx_sum[CW]}}, wx_sum}, 1'b0);
   assign wy = sat({{(ACCW-CW-1){wy_sum[CW]}}, wy_sum}, 1'b0);

   assign mag_max  = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign sq_t     = root_ff + {1'b0, bit_ff};
   assign sq_ge    = sumsq_ff >= sq_t;
   assign root_nx  = sq_ge ? (root_ff >> 1) + {1'b0, bit_ff} : root_ff >> 1;
   assign sumsq_nx = sq_ge ? sumsq_ff - sq_t : sumsq_ff;
   assign len_nx   = {{(LENW-CW){1'b0}}, root_nx[CW-1:0]} << k_ff;

   assign div_d    = {{(REMW-CW){1'b0}}, root_ff[CW-1:0]};
   assign div_take = rem_ff >= div_d;
   assign rem_sub  = div_take ? rem_ff - div_d : rem_ff;
   assign rem_nx   = rem_sub << 1;
   assign quo_nx   = {quo_ff[QW-2:0], div_take};
   assign q_cap    = (32'(quo_nx) > pcc_pkg::NMAX) ? NW'(pcc_pkg::NMAX) : NW'(quo_nx);

   assign prod_sh  = $signed({prod_ff[PW-1], prod_ff}) >>> F;
   assign acc_sh   = acc_ff >>> F;

   always_comb begin
      q_signed = (state_ff == S_VDIVX ? op_x_ff[OPW-1] : op_y_ff[OPW-1])
               ? -$signed(q_cap) : $signed(q_cap);
   end

   always_comb begin
      unique case (state_ff)
         S_VSQ0: begin mul_a = $signed({1'b0, ax_ff}); mul_b = $signed({1'b0, ax_ff}); end
         S_VSQ1: begin mul_a = $signed({1'b0, ay_ff}); mul_b = $signed({1'b0, ay_ff}); end
         S_DOT0: begin mul_a = d_x_ff; mul_b = sxn(nx_ff); end
         S_DOT1: begin mul_a = d_y_ff; mul_b = sxn(ny_ff); end
         S_O0:   begin mul_a = sxn(fn_x_ff); mul_b = $signed({3'b000, r_ff}); end
         S_O1:   begin mul_a = sxn(fn_y_ff); mul_b = $signed({3'b000, r_ff}); end
         S_O2:   begin mul_a = sxn(fn_x_ff); mul_b = sxo(depth_ff); end
         S_O3:   begin mul_a = sxn(fn_y_ff); mul_b = sxo(depth_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.hit      = o_hit_ff;
   assign rsp_ch.depth    = o_depth_ff;
   assign rsp_ch.normal_x = o_nx_ff;
   assign rsp_ch.normal_y = o_ny_ff;
   assign rsp_ch.start_x  = o_sx_ff;
   assign rsp_ch.start_y  = o_sy_ff;
   assign rsp_ch.end_x    = o_ex_ff;
   assign rsp_ch.end_y    = o_ey_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         have_first_ff <= 1'b0;
         outside_ff    <= 1'b0;
         closing_ff    <= 1'b0;
         last_ff       <= 1'b0;
         in_cls_ff     <= 1'b0;
         unit_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_sep_ff   <= S_MIN[CW-1:0];
      end else begin
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  w_x_ff        <= wx;
                  w_y_ff        <= wy;
                  prev_x_ff     <= wx;
                  prev_y_ff     <= wy;
                  cx_ff         <= req_ch.circle_x;
                  cy_ff         <= req_ch.circle_y;
                  r_ff          <= req_ch.circle_radius;
                  last_ff       <= req_ch.last_vertex;
                  have_first_ff <= 1'b1;
                  in_cls_ff     <= 1'b0;
                  closing_ff    <= 1'b0;
                  if (have_first_ff) begin
                     e_x1_ff  <= prev_x_ff;
                     e_y1_ff  <= prev_y_ff;
                     e_x2_ff  <= wx;
                     e_y2_ff  <= wy;
                     state_ff <= S_EDGE;
                  end else begin
                     first_x_ff <= wx;
                     first_y_ff <= wy;
                     if (req_ch.last_vertex) begin
                        e_x1_ff    <= wx;
                        e_y1_ff    <= wy;
                        e_x2_ff    <= wx;
                        e_y2_ff    <= wy;
                        closing_ff <= 1'b1;
                        state_ff   <= S_EDGE;
                     end
                  end
               end
            end
            S_EDGE: begin
               op_x_ff  <= sxo(e_y2_ff) - sxo(e_y1_ff);
               op_y_ff  <= sxo(e_x1_ff) - sxo(e_x2_ff);
               d_x_ff   <= sxo(cx_ff) - sxo(e_x1_ff);
               d_y_ff   <= sxo(cy_ff) - sxo(e_y1_ff);
               unit_ff  <= 1'b1;
               ret_ff   <= S_DOT0;
               state_ff <= S_VABS;
            end
            S_DOT0: state_ff <= S_DOT1;
            S_DOT1: begin
               acc_ff   <= {prod_ff[PW-1], prod_ff};
               state_ff <= S_DOT2;
            end
            S_DOT2: begin
               acc_ff   <= acc_ff + {prod_ff[PW-1], prod_ff};
               state_ff <= in_cls_ff ? S_CPROJ : S_ESEP;
            end
            S_ESEP: begin
               if (sat(acc_sh, 1'b1) > 0) outside_ff <= 1'b1;
               if (sat(acc_sh, 1'b1) > best_sep_ff) begin
                  best_sep_ff <= sat(acc_sh, 1'b1);
                  best_nx_ff  <= nx_ff;
                  best_ny_ff  <= ny_ff;
                  b_x1_ff     <= e_x1_ff;
                  b_y1_ff     <= e_y1_ff;
                  b_x2_ff     <= e_x2_ff;
                  b_y2_ff     <= e_y2_ff;
               end
               if (last_ff && !closing_ff) begin
                  e_x1_ff    <= w_x_ff;
                  e_y1_ff    <= w_y_ff;
                  e_x2_ff    <= first_x_ff;
                  e_y2_ff    <= first_y_ff;
                  closing_ff <= 1'b1;
                  state_ff   <= S_EDGE;
               end else if (last_ff) begin
                  state_ff <= S_CLS;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_CLS: begin
               in_cls_ff <= 1'b1;
               if (outside_ff && best_sep_ff > $signed({1'b0, r_ff})) begin
                  hit_ff   <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  op_x_ff  <= sxo(b_x2_ff) - sxo(b_x1_ff);
                  op_y_ff  <= sxo(b_y2_ff) - sxo(b_y1_ff);
                  d_x_ff   <= sxo(cx_ff) - sxo(b_x1_ff);
                  d_y_ff   <= sxo(cy_ff) - sxo(b_y1_ff);
                  unit_ff  <= 1'b1;
                  ret_ff   <= S_DOT0;
                  state_ff <= S_VABS;
               end
            end
            S_CPROJ: begin
               proj_ff  <= acc_sh;
               unit_ff  <= 1'b0;
               ret_ff   <= S_CCMP;
               state_ff <= S_VABS;
            end
            S_CCMP: begin
               if (proj_ff < 0 || proj_ff > $signed({{(ACCW-LENW){1'b0}}, len_ff})) begin
                  op_x_ff  <= sxo(cx_ff) - sxo(proj_ff < 0 ? b_x1_ff : b_x2_ff);
                  op_y_ff  <= sxo(cy_ff) - sxo(proj_ff < 0 ? b_y1_ff : b_y2_ff);
                  unit_ff  <= 1'b0;
                  ret_ff   <= S_CDIST;
                  state_ff <= S_VABS;
               end else begin
                  depth_ff <= sat($signed({{(ACCW-RW){1'b0}}, r_ff}) - sxa(best_sep_ff), 1'b0);
                  fn_x_ff  <= best_nx_ff;
                  fn_y_ff  <= best_ny_ff;
                  state_ff <= S_O0;
               end
            end
            S_CDIST: begin
               if (len_ff > {{(LENW-RW){1'b0}}, r_ff}) begin
                  hit_ff   <= 1'b0;
                  state_ff <= S_DONE;
               end else begin
                  depth_ff <= sat($signed({{(ACCW-RW){1'b0}}, r_ff})
                                  - $signed({{(ACCW-LENW){1'b0}}, len_ff}), 1'b0);
                  unit_ff  <= 1'b1;
                  ret_ff   <= S_CNRM;
                  state_ff <= S_VABS;
               end
            end
            S_CNRM: begin
               fn_x_ff  <= nx_ff;
               fn_y_ff  <= ny_ff;
               state_ff <= S_O0;
            end
            S_O0: state_ff <= S_O1;
            S_O1: begin
               sx_ff    <= sat(sxa(cx_ff) - prod_sh, 1'b0);
               state_ff <= S_O2;
            end
            S_O2: begin
               sy_ff    <= sat(sxa(cy_ff) - prod_sh, 1'b0);
               state_ff <= S_O3;
            end
            S_O3: begin
               ex_ff    <= sat(sxa(sx_ff) + prod_sh, 1'b0);
               state_ff <= S_O4;
            end
            S_O4: begin
               ey_ff    <= sat(sxa(sy_ff) + prod_sh, 1'b0);
               hit_ff   <= 1'b1;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  o_hit_ff      <= hit_ff;
                  o_depth_ff    <= hit_ff ? depth_ff : '0;
                  o_nx_ff       <= hit_ff ? fn_x_ff : '0;
                  o_ny_ff       <= hit_ff ? fn_y_ff : '0;
                  o_sx_ff       <= hit_ff ? sx_ff : '0;
                  o_sy_ff       <= hit_ff ? sy_ff : '0;
                  o_ex_ff       <= hit_ff ? ex_ff : '0;
                  o_ey_ff       <= hit_ff ? ey_ff : '0;
                  have_first_ff <= 1'b0;
                  outside_ff    <= 1'b0;
                  best_sep_ff   <= S_MIN[CW-1:0];
                  state_ff      <= S_IDLE;
               end
            end
            S_VABS: begin
               ax_ff <= op_x_ff[OPW-1] ? MW'(-op_x_ff) : op_x_ff[MW-1:0];
               ay_ff <= op_y_ff[OPW-1] ? MW'(-op_y_ff) : op_y_ff[MW-1:0];
               k_ff  <= '0;
               if (op_x_ff == 0 && op_y_ff == 0) begin
                  nx_ff    <= '0;
                  ny_ff    <= '0;
                  len_ff   <= '0;
                  state_ff <= ret_ff;
               end else begin
                  state_ff <= S_VNORM;
               end
            end
            S_VNORM: begin
               if (mag_max[MW-1:CW-1] != 0) begin
                  ax_ff <= ax_ff >> 1;
                  ay_ff <= ay_ff >> 1;
                  k_ff  <= k_ff + 2'd1;
               end else if (unit_ff && mag_max[MW-1:CW-2] == 0) begin
                  ax_ff <= ax_ff << 1;
                  ay_ff <= ay_ff << 1;
               end else begin
                  state_ff <= S_VSQ0;
               end
            end
            S_VSQ0: state_ff <= S_VSQ1;
            S_VSQ1: begin
               sumsq_ff <= prod_ff[SQW-1:0];
               state_ff <= S_VSQ2;
            end
            S_VSQ2: begin
               sumsq_ff <= sumsq_ff + prod_ff[SQW-1:0];
               root_ff  <= '0;
               bit_ff   <= {1'b1, {(SQW-2){1'b0}}};
               state_ff <= S_VSQRT;
            end
            S_VSQRT: begin
               root_ff  <= root_nx;
               sumsq_ff <= sumsq_nx;
               bit_ff   <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  if (unit_ff) begin
                     rem_ff   <= {{(REMW-MW){1'b0}}, ax_ff};
                     quo_ff   <= '0;
                     dcnt_ff  <= DCW'(F);
                     state_ff <= S_VDIVX;
                  end else begin
                     len_ff   <= len_nx;
                     state_ff <= ret_ff;
                  end
               end
            end
            S_VDIVX: begin
               if (dcnt_ff == 0) begin
                  nx_ff    <= q_signed;
                  rem_ff   <= {{(REMW-MW){1'b0}}, ay_ff};
                  quo_ff   <= '0;
                  dcnt_ff  <= DCW'(F);
                  state_ff <= S_VDIVY;
               end else begin
                  rem_ff  <= rem_nx;
                  quo_ff  <= quo_nx;
                  dcnt_ff <= dcnt_ff - 1'b1;
               end
            end
            S_VDIVY: begin
               if (dcnt_ff == 0) begin
                  ny_ff    <= q_signed;
                  state_ff <= ret_ff;
               end else begin
                  rem_ff  <= rem_nx;
                  quo_ff  <= quo_nx;
                  dcnt_ff <= dcnt_ff - 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the streamed polygon/circle collision block.
`default_nettype none
module tb_top;

   typedef struct packed {
      logic                                  hit;
      logic signed [pcc_pkg::CW-1:0] depth;
      logic signed [pcc_pkg::NW-1:0] normal_x;
      logic signed [pcc_pkg::NW-1:0] normal_y;
      logic signed [pcc_pkg::CW-1:0] start_x;
      logic signed [pcc_pkg::CW-1:0] start_y;
      logic signed [pcc_pkg::CW-1:0] end_x;
      logic signed [pcc_pkg::CW-1:0] end_y;
   } contact_type;

   localparam int     CW       = pcc_pkg::CW;
   localparam int     NW       = pcc_pkg::NW;
   localparam int     RW       = pcc_pkg::RW;
   localparam longint S32MAX   = 64'sd2147483647;
   localparam longint S32MIN   = -64'sd2147483648;
   localparam int     IDLE_MAX = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pcc_req_if req_ch ();
   pcc_rsp_if rsp_ch ();

   polygon_circle_collision uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #10 clock = ~clock;

   // polygon state of the predictor
   bit     poly_open;
   longint first_x, first_y, prev_x, prev_y;
   longint best_sep, best_nx, best_ny;
   longint edge_x1, edge_y1, edge_x2, edge_y2;
   bit     outside;

   contact_type contacts_due[$];
   int       mismatches;
   int       items_sent;
   int       idle_cycles;
   bit       quiet;
   int       hold_off;

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint fix_floor(longint v);
      return v >>> pcc_pkg::FRAC_BITS;
   endfunction

   function automatic longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   task automatic unit_of(input longint x, input longint y, output longint nx, output longint ny);
      longint unsigned ax, ay, m, len, qx, qy;
      ax = mag(x);
      ay = mag(y);
      nx = 0;
      ny = 0;
      m  = ax > ay ? ax : ay;
      if (m != 0) begin
         while (m >= (64'd1 << 31)) begin ax = ax >> 1; ay = ay >> 1; m = m >> 1; end
         while (m < (64'd1 << 30)) begin ax = ax << 1; ay = ay << 1; m = m << 1; end
         len = int_root(ax * ax + ay * ay);
         qx  = (ax << pcc_pkg::FRAC_BITS) / len;
         qy  = (ay << pcc_pkg::FRAC_BITS) / len;
         if (qx > pcc_pkg::NMAX) qx = pcc_pkg::NMAX;
         if (qy > pcc_pkg::NMAX) qy = pcc_pkg::NMAX;
         nx = x < 0 ? -longint'(qx) : longint'(qx);
         ny = y < 0 ? -longint'(qy) : longint'(qy);
      end
   endtask

   function automatic longint length_of(longint x, longint y);
      longint unsigned ax, ay, m;
      int k;
      ax = mag(x);
      ay = mag(y);
      k  = 0;
      m  = ax > ay ? ax : ay;
      while (m >= (64'd1 << 31)) begin ax = ax >> 1; ay = ay >> 1; m = m >> 1; k++; end
      return longint'(int_root(ax * ax + ay * ay) << k);
   endfunction

   task automatic close_edge(input longint x1, input longint y1, input longint x2,
                             input longint y2, input longint cx, input longint cy);
      longint nx, ny, sep;
      unit_of(y2 - y1, -(x2 - x1), nx, ny);
      sep = sat(fix_floor((cx - x1) * nx + (cy - y1) * ny), S32MIN + 1, S32MAX);
      if (sep > 0) outside = 1'b1;
      if (sep > best_sep) begin
         best_sep = sep;
         best_nx  = nx;
         best_ny  = ny;
         edge_x1  = x1;
         edge_y1  = y1;
         edge_x2  = x2;
         edge_y2  = y2;
      end
   endtask

   function automatic void clear_polygon();
      poly_open = 1'b0;
      first_x   = 0;
      first_y   = 0;
      prev_x    = 0;
      prev_y    = 0;
      best_sep  = S32MIN;
      best_nx   = 0;
      best_ny   = 0;
      edge_x1   = 0;
      edge_y1   = 0;
      edge_x2   = 0;
      edge_y2   = 0;
      outside   = 1'b0;
   endfunction

   task automatic classify(input longint cx, input longint cy, input longint r,
                           output contact_type c);
      longint dx, dy, proj, depth, nx, ny, vx, vy, vdist, sx, sy, ex, ey;
      c = '0;
      if (!(outside && best_sep > r)) begin
         unit_of(edge_x2 - edge_x1, edge_y2 - edge_y1, dx, dy);
         proj = fix_floor((cx - edge_x1) * dx + (cy - edge_y1) * dy);
         if (proj < 0 || proj > length_of(edge_x2 - edge_x1, edge_y2 - edge_y1)) begin
            vx    = proj < 0 ? edge_x1 : edge_x2;
            vy    = proj < 0 ? edge_y1 : edge_y2;
            vdist = length_of(cx - vx, cy - vy);
            if (vdist > r) return;
            depth = r - vdist;
            unit_of(cx - vx, cy - vy, nx, ny);
         end else begin
            depth = r - best_sep;
            nx    = best_nx;
            ny    = best_ny;
         end
         depth      = sat(depth, S32MIN, S32MAX);
         sx         = sat(cx - fix_floor(nx * r), S32MIN, S32MAX);
         sy         = sat(cy - fix_floor(ny * r), S32MIN, S32MAX);
         ex         = sat(sx + fix_floor(nx * depth), S32MIN, S32MAX);
         ey         = sat(sy + fix_floor(ny * depth), S32MIN, S32MAX);
         c.hit      = 1'b1;
         c.depth    = depth[CW-1:0];
         c.normal_x = nx[NW-1:0];
         c.normal_y = ny[NW-1:0];
         c.start_x  = sx[CW-1:0];
         c.start_y  = sy[CW-1:0];
         c.end_x    = ex[CW-1:0];
         c.end_y    = ey[CW-1:0];
      end
   endtask

   task automatic predict_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                                 input logic last, input logic signed [CW-1:0] px,
                                 input logic signed [CW-1:0] py, input logic signed [CW-1:0] cx,
                                 input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
      longint      wx, wy;
      contact_type c;
      wx = sat(longint'(vx) + longint'(px), S32MIN, S32MAX);
      wy = sat(longint'(vy) + longint'(py), S32MIN, S32MAX);
      if (poly_open) begin
         close_edge(prev_x, prev_y, wx, wy, longint'(cx), longint'(cy));
      end else begin
         poly_open = 1'b1;
         first_x   = wx;
         first_y   = wy;
      end
      prev_x = wx;
      prev_y = wy;
      if (last) begin
         close_edge(wx, wy, first_x, first_y, longint'(cx), longint'(cy));
         classify(longint'(cx), longint'(cy), longint'({1'b0, r}), c);
         contacts_due.push_back(c);
         clear_polygon();
      end
   endtask

   task automatic send_gap();
      int n;
      if (quiet) return;
      n = $urandom_range(0, 99);
      if (n < 60) return;
      req_ch.valid <= 1'b0;
      if (n < 96) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 40)) @(posedge clock);
   endtask

   task automatic send_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                              input logic last, input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py, input logic signed [CW-1:0] cx,
                              input logic signed [CW-1:0] cy, input logic [RW-1:0] r);
      req_ch.valid         <= 1'b1;
      req_ch.vertex_x      <= vx;
      req_ch.vertex_y      <= vy;
      req_ch.last_vertex   <= last;
      req_ch.poly_pos_x    <= px;
      req_ch.poly_pos_y    <= py;
      req_ch.circle_x      <= cx;
      req_ch.circle_y      <= cy;
      req_ch.circle_radius <= r;
      do @(posedge clock); while (!req_ch.ready);
      predict_vertex(vx, vy, last, px, py, cx, cy, r);
      items_sent++;
      send_gap();
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (contacts_due.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   // square of half-side h (Q16.16) wound clockwise around the position
   task automatic send_square(input int h, input int px, input int py, input int cx,
                              input int cy, input int r);
      send_vertex(-h, -h, 1'b0, px, py, cx, cy, RW'(r));
      send_vertex(-h, h, 1'b0, px, py, cx, cy, RW'(r));
      send_vertex(h, h, 1'b0, px, py, cx, cy, RW'(r));
      send_vertex(h, -h, 1'b1, px, py, cx, cy, RW'(r));
   endtask

   task automatic test_directed();
      send_square(32'sh4_0000, 0, 0, 0, 0, 32'h1_0000);
      send_square(32'sh4_0000, 0, 0, 32'shA_0000, 0, 32'h1_0000);
      send_square(32'sh4_0000, 0, 0, 32'sh5_0000, 32'sh5_0000, 32'h2_0000);
      send_vertex(0, 0, 1'b1, 0, 0, 0, 0, 31'h1_0000);
      send_vertex(32'sh1_0000, 0, 1'b0, 0, 0, 0, 0, 31'h3_0000);
      send_vertex(32'sh1_0000, 0, 1'b0, 0, 0, 0, 0, 31'h3_0000);
      send_vertex(0, 32'sh1_0000, 1'b1, 0, 0, 0, 0, 31'h3_0000);
      send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 31'h7fffffff);
      send_vertex(32'sh80000000, 32'sh80000000, 1'b1, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
      send_vertex(32'sh80000000, 32'sh7fffffff, 1'b0, 0, 0, 0, 0, 31'h0);
      send_vertex(32'sh7fffffff, 32'sh80000000, 1'b1, 32'sh1234, 0, 0, 0, 31'h0);
   endtask

   task automatic send_noise();
      send_vertex($urandom, $urandom, $urandom_range(0, 3) == 0, $urandom, $urandom,
                  $urandom, $urandom, RW'($urandom));
   endtask

   task automatic send_polygon();
      int  n, k;
      real scale, a0, ang, rad;
      int  px, py, cx, cy, r, vx, vy;
      n     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      scale = 2.0 ** $urandom_range(10, 28);
      px    = $signed($urandom) >>> $urandom_range(1, 12);
      py    = $signed($urandom) >>> $urandom_range(1, 12);
      a0    = $urandom_range(0, 6283) / 1000.0;
      cx    = px + $rtoi(scale * ($urandom_range(0, 3000) / 1000.0 - 1.5));
      cy    = py + $rtoi(scale * ($urandom_range(0, 3000) / 1000.0 - 1.5));
      r     = $rtoi(scale * $urandom_range(0, 1200) / 1000.0);
      for (k = 0; k < n; k++) begin
         ang = a0 - 6.283185 * (k + $urandom_range(0, 40) / 100.0) / n;
         rad = scale * (0.8 + $urandom_range(0, 20) / 100.0);
         vx  = $rtoi(rad * $cos(ang));
         vy  = $rtoi(rad * $sin(ang));
         send_vertex(vx, vy, k == n - 1, px, py, cx, cy, RW'(r));
      end
   endtask

   task automatic test_random(input int target);
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_polygon();
      end
   endtask

   task automatic test_backpressure();
      hold_off = 3000;
      test_random(items_sent + 40);
      drain();
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      test_random(items_sent + 150);
      quiet = 1'b0;
      drain();
   endtask

   // response side: checks at the accepting edge, then picks the next ready
   initial begin
      contact_type want, got;
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.hit, rsp_ch.depth, rsp_ch.normal_x, rsp_ch.normal_y,
                    rsp_ch.start_x, rsp_ch.start_y, rsp_ch.end_x, rsp_ch.end_y};
            if (contacts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = contacts_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("contact mismatch\n exp %p\n got %p", want, got);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 99) < 25)
               stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(1, 4);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.vertex_x      = '0;
      req_ch.vertex_y      = '0;
      req_ch.last_vertex   = 1'b0;
      req_ch.poly_pos_x    = '0;
      req_ch.poly_pos_y    = '0;
      req_ch.circle_x      = '0;
      req_ch.circle_y      = '0;
      req_ch.circle_radius = '0;
      rsp_ch.ready         = 1'b0;
      mismatches           = 0;
      items_sent           = 0;
      idle_cycles          = 0;
      quiet                = 1'b0;
      hold_off             = 0;
      clear_polygon();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_backpressure();
      test_back_to_back();
      test_random(1650);
      drain();
      if (mismatches == 0 && contacts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
